/* hw/rtl/sfbp_pkg.sv */
// Shared types, codes and sizes of the segmented FIFO block pool.
package sfbp_pkg;

    // Pool capacity; link memory depth and block index width follow from it.
    localparam int NUM_BLOCKS = 1024;
    localparam int ADDR_W     = $clog2(NUM_BLOCKS);
    localparam int CNT_W      = 11;
    localparam int SIZE_W     = 16;
    localparam int CTR_W      = 32;

    // Largest usable block count.
    localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'((NUM_BLOCKS < 1024) ? NUM_BLOCKS : 1024);
    localparam logic [CNT_W-1:0] AVAIL_MAX = 11'd2047;

    // Segmenting thresholds.
    localparam logic [CNT_W-1:0] BIG_COUNT_MIN = 11'd50;
    localparam logic [26:0]      BIG_BYTES_MIN = 27'd20480;
    // ceil(1024 / 5): x / 5 == (x * RECIP5) >> 10 whenever 5 divides x <= 1024
    localparam logic [7:0]       RECIP5        = 8'd205;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Config register indexes
    localparam int             CFG_ADDR_W      = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_SIZE  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_BIG   = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_OWNED = 2'd3
    } t_status;

    // One link memory entry: valid flag plus next block index.
    typedef struct packed {
        logic              ok;
        logic [ADDR_W-1:0] idx;
    } t_link;

    // Link memory access from the controller.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_link             wdata;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // Pool geometry derived from the config registers.
    typedef struct packed {
        logic [SIZE_W-1:0] bsize;
        logic [CNT_W-1:0]  cnt;
        logic [CNT_W-1:0]  seg;
    } t_geom;

    // One result word.
    typedef struct packed {
        t_status           status;
        logic [ADDR_W-1:0] granted;
        logic [CNT_W-1:0]  free_count;
        logic [CNT_W-1:0]  low_wm;
        logic [CTR_W-1:0]  total;
        logic [CTR_W-1:0]  failed;
    } t_result;

endpackage

/* hw/rtl/sfbp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module sfbp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 11
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/sfbp_geom.sv */
// Config registers and the three-stage pipeline that derives segment size.
module sfbp_geom (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [sfbp_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [sfbp_pkg::SIZE_W-1:0]        i_cfg_wdata,
    output sfbp_pkg::t_geom                    o_geom
);

    logic [sfbp_pkg::SIZE_W-1:0] r_bsize;
    logic [sfbp_pkg::CNT_W-1:0]  r_bcount;

    // stage 1: clamped count
    logic [sfbp_pkg::CNT_W-1:0]  r_cnt1;
    // stage 2: bytes product and count / 5 candidate
    logic [26:0]                 r_prod;
    logic [sfbp_pkg::CNT_W-1:0]  r_q5;
    logic [sfbp_pkg::CNT_W-1:0]  r_cnt2;
    // stage 3: result
    logic [sfbp_pkg::CNT_W-1:0]  r_cnt3;
    logic [sfbp_pkg::CNT_W-1:0]  r_seg;

    logic [sfbp_pkg::CNT_W-1:0]  n_cnt1;
    logic [18:0]                 q5_prod;
    logic [12:0]                 q5_back;
    logic                        big;
    logic [sfbp_pkg::CNT_W-1:0]  n_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bsize  <= 16'd64;
            r_bcount <= 11'd1024;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == sfbp_pkg::REG_BLOCK_SIZE) begin
                r_bsize <= i_cfg_wdata;
            end else begin
                r_bcount <= i_cfg_wdata[sfbp_pkg::CNT_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_bcount == '0) begin
            n_cnt1 = 11'd1;
        end else if (r_bcount > sfbp_pkg::MAX_CNT) begin
            n_cnt1 = sfbp_pkg::MAX_CNT;
        end else begin
            n_cnt1 = r_bcount;
        end
    end

    assign q5_prod = 19'(r_cnt1) * 19'(sfbp_pkg::RECIP5);

    // q5 * 5 by shift and add; equal to the count only if 5 divides it
    assign q5_back = {r_q5, 2'b00} + 13'(r_q5);
    assign big     = (r_cnt2 >= sfbp_pkg::BIG_COUNT_MIN) && (r_prod >= sfbp_pkg::BIG_BYTES_MIN);

    always_comb begin
        if (big && (q5_back == 13'(r_cnt2))) begin
            n_seg = r_q5;
        end else if (big && (r_cnt2[1:0] == 2'b00)) begin
            n_seg = r_cnt2 >> 2;
        end else begin
            n_seg = r_cnt2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt1 <= n_cnt1;
        r_prod <= 27'(r_cnt1) * 27'(r_bsize);
        r_q5   <= 11'(q5_prod[18:10]);
        r_cnt2 <= r_cnt1;
        r_cnt3 <= r_cnt2;
        r_seg  <= n_seg;
    end

    assign o_geom.bsize = r_bsize;
    assign o_geom.cnt   = r_cnt3;
    assign o_geom.seg   = r_seg;

endmodule

/* hw/rtl/sfbp_ctrl.sv */
// Free-list sequencer: allocate, free, segment activation and statistics.
module sfbp_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  sfbp_pkg::t_geom               i_geom,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic                          i_cmd,
    input  logic [sfbp_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [sfbp_pkg::ADDR_W-1:0]   i_block_index,
    input  logic                          i_out_free,
    output logic                          o_pend,
    output sfbp_pkg::t_result             o_result,
    output sfbp_pkg::t_ram_req            o_ram,
    input  sfbp_pkg::t_link               i_rdata
);

    typedef enum logic [2:0] {
        S_CALC,
        S_IDLE,
        S_READ,
        S_FREE,
        S_WALK
    } t_state;

    localparam int AW = sfbp_pkg::ADDR_W;
    localparam int CW = sfbp_pkg::CNT_W;

    t_state                     r_state, n_state;
    logic [1:0]                 r_wait, n_wait;
    logic                       r_pend, n_pend;
    logic [AW-1:0]              r_head, n_head;
    logic                       r_head_ok, n_head_ok;
    logic [AW-1:0]              r_tail, n_tail;
    logic                       r_tail_ok, n_tail_ok;
    logic [CW-1:0]              r_lim, n_lim;
    logic [CW-1:0]              r_base, n_base;
    logic [CW-1:0]              r_wi, n_wi;
    logic [CW-1:0]              r_avail, n_avail;
    logic [CW-1:0]              r_lowest, n_lowest;
    logic [sfbp_pkg::CTR_W-1:0] r_total, n_total;
    logic [sfbp_pkg::CTR_W-1:0] r_failed, n_failed;
    sfbp_pkg::t_status          r_status, n_status;
    logic [AW-1:0]              r_gnt, n_gnt;
    logic [AW-1:0]              r_fidx, n_fidx;

    logic                       accept;
    logic [CW-1:0]              walk_blk;
    logic                       walk_last;
    logic [CW-1:0]              dec_avail;

    assign o_s_tready = (r_state == S_IDLE) && (!r_pend || i_out_free);
    assign accept     = i_s_tvalid && o_s_tready;
    assign walk_blk   = r_base + r_wi;
    assign walk_last  = (r_wi + 11'd1) == i_geom.seg;
    assign dec_avail  = (r_avail != '0) ? r_avail - 11'd1 : '0;

    always_comb begin
        n_state   = r_state;
        n_wait    = r_wait;
        n_pend    = r_pend && !i_out_free;
        n_head    = r_head;
        n_head_ok = r_head_ok;
        n_tail    = r_tail;
        n_tail_ok = r_tail_ok;
        n_lim     = r_lim;
        n_base    = r_base;
        n_wi      = r_wi;
        n_avail   = r_avail;
        n_lowest  = r_lowest;
        n_total   = r_total;
        n_failed  = r_failed;
        n_status  = r_status;
        n_gnt     = r_gnt;
        n_fidx    = r_fidx;

        o_ram.we    = 1'b0;
        o_ram.waddr = r_head;
        o_ram.wdata = '0;
        o_ram.raddr = r_head;

        unique case (r_state)
            S_CALC: begin
                // wait out the geometry pipeline, then build segment 0
                n_wait = r_wait + 2'd1;
                if (r_wait == 2'd3) begin
                    n_avail  = i_geom.cnt;
                    n_lowest = i_geom.cnt;
                    n_total  = '0;
                    n_failed = '0;
                    n_lim    = '0;
                    n_base   = '0;
                    n_wi     = '0;
                    n_state  = S_WALK;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_gnt = '0;
                    if (i_cmd == sfbp_pkg::CMD_ALLOC) begin
                        if (i_req_size > i_geom.bsize) begin
                            n_status = sfbp_pkg::ST_TOO_BIG;
                            n_failed = r_failed + 32'd1;
                            n_pend   = 1'b1;
                        end else if (!r_head_ok) begin
                            n_status = sfbp_pkg::ST_EMPTY;
                            n_failed = r_failed + 32'd1;
                            n_pend   = 1'b1;
                        end else begin
                            // link of the head block comes back next cycle
                            n_gnt   = r_head;
                            n_state = S_READ;
                        end
                    end else begin
                        if (CW'(i_block_index) >= r_lim) begin
                            n_status = sfbp_pkg::ST_NOT_OWNED;
                            n_pend   = 1'b1;
                        end else begin
                            // freed block becomes the new end of list
                            o_ram.we    = 1'b1;
                            o_ram.waddr = i_block_index;
                            n_fidx      = i_block_index;
                            n_state     = S_FREE;
                        end
                    end
                end
            end
            S_READ: begin
                n_head    = i_rdata.idx;
                n_head_ok = i_rdata.ok;
                n_status  = sfbp_pkg::ST_OK;
                n_pend    = 1'b1;
                n_avail   = dec_avail;
                n_lowest  = (dec_avail < r_lowest) ? dec_avail : r_lowest;
                n_total   = r_total + 32'd1;
                n_state   = S_IDLE;
                if (!i_rdata.ok) begin
                    if (r_lim < i_geom.cnt) begin
                        n_base  = r_lim;
                        n_wi    = '0;
                        n_state = S_WALK;
                    end else begin
                        n_tail_ok = 1'b0;
                    end
                end
            end
            S_FREE: begin
                if (r_tail_ok) begin
                    o_ram.we        = 1'b1;
                    o_ram.waddr     = r_tail;
                    o_ram.wdata.ok  = 1'b1;
                    o_ram.wdata.idx = r_fidx;
                end
                n_tail    = r_fidx;
                n_tail_ok = 1'b1;
                if (!r_head_ok) begin
                    n_head    = r_fidx;
                    n_head_ok = 1'b1;
                end
                if (r_avail < sfbp_pkg::AVAIL_MAX) begin
                    n_avail = r_avail + 11'd1;
                end
                n_status = sfbp_pkg::ST_OK;
                n_pend   = 1'b1;
                n_state  = S_IDLE;
            end
            S_WALK: begin
                // chain base .. base+seg-1, last entry null
                o_ram.we        = 1'b1;
                o_ram.waddr     = walk_blk[AW-1:0];
                o_ram.wdata.ok  = !walk_last;
                o_ram.wdata.idx = walk_last ? '0 : AW'(walk_blk + 11'd1);
                if (walk_last) begin
                    n_head    = r_base[AW-1:0];
                    n_head_ok = 1'b1;
                    n_tail    = walk_blk[AW-1:0];
                    n_tail_ok = 1'b1;
                    n_lim     = r_base + i_geom.seg;
                    n_state   = S_IDLE;
                end else begin
                    n_wi = r_wi + 11'd1;
                end
            end
            default: begin
                n_state = S_CALC;
            end
        endcase

        if (i_cfg_we) begin
            n_state = S_CALC;
            n_wait  = '0;
            n_pend  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CALC;
            r_wait    <= '0;
            r_pend    <= 1'b0;
            r_head_ok <= 1'b0;
            r_tail_ok <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wait    <= n_wait;
            r_pend    <= n_pend;
            r_head_ok <= n_head_ok;
            r_tail_ok <= n_tail_ok;
        end
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_lim    <= n_lim;
        r_base   <= n_base;
        r_wi     <= n_wi;
        r_avail  <= n_avail;
        r_lowest <= n_lowest;
        r_total  <= n_total;
        r_failed <= n_failed;
        r_status <= n_status;
        r_gnt    <= n_gnt;
        r_fidx   <= n_fidx;
    end

    assign o_pend              = r_pend;
    assign o_result.status     = r_status;
    assign o_result.granted    = r_gnt;
    assign o_result.free_count = r_avail;
    assign o_result.low_wm     = r_lowest;
    assign o_result.total      = r_total;
    assign o_result.failed     = r_failed;

endmodule

/* hw/rtl/segmented_fifo_block_pool.sv */
// Top level of the segmented FIFO block pool allocator.
//
//  channel | dir | handshake             | fields
//  --------+-----+-----------------------+------------------------------------------------
//  cfg     | in  | i_cfg_we              | i_cfg_addr (0 size, 1 count), i_cfg_wdata
//  request | in  | i_s_tvalid/o_s_tready | tuser cmd; tdata req_size, block_index
//  result  | out | o_m_tvalid/i_m_tready | tuser status; tdata granted, free, low wm, counts
//
//  A failed allocate or an unowned free is answered from S_IDLE; a good allocate also reads
//  the head's link (S_READ), a free writes the freed block's link, then the old tail's if any
//  (S_FREE), and an allocate that links in a new segment walks S_WALK, one link write per
//  block. Reset and every config write rebuild the pool: S_CALC derives the segment size,
//  S_WALK chains segment 0 (up to 1024 blocks), o_s_tready low throughout. A result in the
//  output register does not stop the next request; only a second result finding it still full holds o_s_tready low.
module segmented_fifo_block_pool (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // config write port
    input  logic                                i_cfg_we,
    input  logic [sfbp_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [sfbp_pkg::SIZE_W-1:0]         i_cfg_wdata,
    // request stream
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    input  logic [31:0]                         i_s_tdata,  // [15:0] req_size, [25:16] block_index
    input  logic                                i_s_tuser,  // [0] cmd
    // result stream
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [9:0] granted_index, [20:10] free_count, [31:21] low_watermark,
    // [63:32] total_allocs, [95:64] failed_allocs
    output logic [95:0]                         o_m_tdata,
    output logic [1:0]                          o_m_tuser   // [1:0] status
);

    sfbp_pkg::t_geom    geom;
    sfbp_pkg::t_ram_req ram_req;
    sfbp_pkg::t_link    ram_rdata;
    sfbp_pkg::t_result  result;
    logic               pend;
    logic               out_free;

    logic               r_m_valid;
    sfbp_pkg::t_result  r_out;

    sfbp_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_geom      (geom)
    );

    // next_link memory: one entry per block, valid flag + next index
    sfbp_ram #(
        .DEPTH (sfbp_pkg::NUM_BLOCKS),
        .WIDTH ($bits(sfbp_pkg::t_link))
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    sfbp_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_geom        (geom),
        .i_s_tvalid    (i_s_tvalid),
        .o_s_tready    (o_s_tready),
        .i_cmd         (i_s_tuser),
        .i_req_size    (i_s_tdata[15:0]),
        .i_block_index (i_s_tdata[25:16]),
        .i_out_free    (out_free),
        .o_pend        (pend),
        .o_result      (result),
        .o_ram         (ram_req),
        .i_rdata       (ram_rdata)
    );

    // output register: loads the pending result whenever it is empty or draining
    assign out_free = !r_m_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= pend;
        end
        if (out_free && pend) begin
            r_out <= result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_out.status;
    assign o_m_tdata  = {r_out.failed, r_out.total, r_out.low_wm, r_out.free_count,
                         r_out.granted};

endmodule

/* hw/rtl/sfbp_checker.sv */
// Port-level assertions for the block pool, bound to the top level.
module sfbp_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [95:0]                       o_m_tdata,
    input logic [1:0]                        o_m_tuser
);

    // result held until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result dropped or changed while stalled");

    // pool is rebuilt after reset or a config write: no request taken in the next cycle
    a_rebuild: assert property (@(posedge i_clk)
        !i_rst_n || i_cfg_we |=> !o_s_tready)
        else $error("request accepted while pool rebuilds");

    // low watermark never above the free count
    a_wm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[31:21] <= o_m_tdata[20:10])
        else $error("low watermark above free count");

    // a failed word never carries a granted block
    a_gnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != sfbp_pkg::ST_OK) |-> o_m_tdata[9:0] == '0)
        else $error("granted index on a failed word");

endmodule

bind segmented_fifo_block_pool sfbp_checker u_sfbp_checker (.*);
